FILE: rtl/skt_pkg.sv
// skt_pkg: sizes, key type and request/status codes of the sorted key table
// used by the channel interfaces and by the top level; no dependencies
`default_nettype none

package skt_pkg;

  // table sizing
  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;
  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  // fixed port field widths
  localparam int REQ_TYPE_BITS = 2;
  localparam int PORT_KEY_BITS = 32;
  localparam int STATUS_BITS   = 2;
  localparam int COUNT_BITS    = 5;

  typedef logic [REQ_TYPE_BITS-1:0]        req_type_t;
  typedef logic signed [PORT_KEY_BITS-1:0] port_key_t;
  typedef logic [STATUS_BITS-1:0]          status_t;
  typedef logic [COUNT_BITS-1:0]           entry_count_t;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [IDX_BITS-1:0]        idx_t;
  typedef logic [CNT_BITS-1:0]        cnt_t;

  // request codes
  localparam req_type_t OP_INSERT = 2'd0;
  localparam req_type_t OP_DELETE = 2'd1;
  localparam req_type_t OP_SEARCH = 2'd2;

  // status codes
  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_ABSENT = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/skt_req_if.sv
// skt_req_if: request channel (operation and key) with valid/ready handshake
// depends on skt_pkg
`default_nettype none

interface skt_req_if;
  import skt_pkg::*;

  logic      valid;
  logic      ready;
  req_type_t req_type;
  port_key_t key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);

endinterface

`default_nettype wire

FILE: rtl/skt_rsp_if.sv
// skt_rsp_if: response channel (status and entry count) with valid/ready handshake
// depends on skt_pkg
`default_nettype none

interface skt_rsp_if;
  import skt_pkg::*;

  logic         valid;
  logic         ready;
  status_t      status;
  entry_count_t entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink (input valid, input status, input entry_count, output ready);

endinterface

`default_nettype wire

FILE: rtl/sorted_key_table.sv
// sorted_key_table: bounded table of signed keys in ascending order, held in one
// synchronous memory and updated by a scan/shift sequencer
// depends on skt_pkg, skt_req_if, skt_rsp_if
//
//   channel  dir  payload                 notes
//   req      in   req_type, key           taken only while the sequencer is idle
//   rsp      out  status, entry_count     one response per request, registered
//
// the key memory has one read and one write port; the sequencer visits one
// entry per cycle. a search or delete walks the stored keys, a search stopping
// at a hit; an insert walks down over the keys not smaller than the new one,
// shifting each up; full-table, empty-table and unused requests skip the walk.
// synchronous reset empties the table at once; memory contents are not cleared.
// a response waiting on rsp.ready holds the sequencer before its return to idle.
`default_nettype none

module sorted_key_table (
  input  wire logic clk,
  input  wire logic rst,
  skt_req_if.sink   req,
  skt_rsp_if.source rsp
);
  import skt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_SCAN,
    S_DONE
  } state_t;

  state_t       state;
  cnt_t         cnt;
  idx_t         p;
  key_t         key_r;
  req_type_t    op;
  logic         found;
  status_t      result;
  logic         rsp_valid;
  status_t      rsp_status;
  entry_count_t rsp_count;

  key_t mem [CAPACITY];
  key_t rd_data;
  idx_t rd_addr;
  logic wr_en;
  idx_t wr_addr;
  key_t wr_data;

  logic accept;
  key_t key_in;
  logic hit;
  logic last;
  logic found_now;

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign key_in          = key_t'(req.key);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.entry_count = rsp_count;

  assign hit       = (rd_data == key_r);
  assign last      = ((cnt_t'(p) + cnt_t'(1)) == cnt);
  assign found_now = found || hit;

  // read address: top entry for insert, first entry for scans, then walk
  always_comb begin
    case (state)
      S_INS:   rd_addr = p - idx_t'(1);
      S_SCAN:  rd_addr = p + idx_t'(1);
      default: rd_addr = (req.req_type == OP_INSERT) ? idx_t'(cnt - cnt_t'(1)) : '0;
    endcase
  end

  // write port: first key into an empty table, shift up for insert, shift down behind a deleted key
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = key_r;
    case (state)
      S_IDLE: begin
        if (accept && req.req_type == OP_INSERT && cnt == '0) begin
          wr_en   = 1'b1;
          wr_data = key_in;
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = p + idx_t'(1);
        wr_data = (rd_data >= key_r) ? rd_data : key_r;
      end
      S_INS_LAST: begin
        wr_en = 1'b1;
      end
      S_SCAN: begin
        if (op == OP_DELETE && found) begin
          wr_en   = 1'b1;
          wr_addr = p - idx_t'(1);
          wr_data = rd_data;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // key memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key_r <= key_in;
            op    <= req.req_type;
            found <= 1'b0;
            p     <= (req.req_type == OP_INSERT) ? idx_t'(cnt - cnt_t'(1)) : '0;
            case (req.req_type)
              OP_INSERT: begin
                if (cnt == cnt_t'(CAPACITY)) begin
                  result <= ST_FULL;
                  state  <= S_DONE;
                end else if (cnt == '0) begin
                  cnt    <= cnt_t'(1);
                  result <= ST_DONE;
                  state  <= S_DONE;
                end else begin
                  state <= S_INS;
                end
              end
              OP_DELETE, OP_SEARCH: begin
                if (cnt == '0) begin
                  result <= ST_ABSENT;
                  state  <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                result <= ST_ABSENT;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          if (rd_data >= key_r) begin
            if (p == '0) begin
              state <= S_INS_LAST;
            end else begin
              p <= p - idx_t'(1);
            end
          end else begin
            cnt    <= cnt + cnt_t'(1);
            result <= ST_DONE;
            state  <= S_DONE;
          end
        end
        S_INS_LAST: begin
          cnt    <= cnt + cnt_t'(1);
          result <= ST_DONE;
          state  <= S_DONE;
        end
        S_SCAN: begin
          if (op == OP_SEARCH && hit) begin
            result <= ST_DONE;
            state  <= S_DONE;
          end else if (last) begin
            if (found_now && op == OP_DELETE) begin
              cnt    <= cnt - cnt_t'(1);
              result <= ST_DONE;
            end else begin
              result <= ST_ABSENT;
            end
            state <= S_DONE;
          end else begin
            p     <= p + idx_t'(1);
            found <= found_now;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= result;
            rsp_count  <= entry_count_t'(cnt);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // table never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");

  // a rejected insert is reported only with a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_count == entry_count_t'(CAPACITY))
    else $error("full status with table not full");

  // ready is low in the cycle after a request is accepted
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while busy");

  // the insert walk stays inside the stored entries
  a_ins_index: assert property (@(posedge clk) disable iff (rst)
    state == S_INS |-> cnt_t'(p) < cnt)
    else $error("insert index beyond stored entries");

  // count moves by at most one per request
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !req.ready && $past(!req.ready) |-> cnt == $past(cnt) || cnt == $past(cnt) + cnt_t'(1)
      || cnt == $past(cnt) - cnt_t'(1))
    else $error("entry count jumped");

endmodule

`default_nettype wire
